// File: sv/kvte_pkg.sv
// kvte_pkg: shared types and constants of the key/value table engine
// depends on nothing; imported by the controller, the datapath and the top level
package kvte_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 64;
    localparam int KEY_BYTES     = 8;
    localparam int NUMBER_DIGITS = 10;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = KEY_BYTES * 8;
    localparam int DIG_W = (NUMBER_DIGITS * 4 > 40) ? 40 : NUMBER_DIGITS * 4;
    localparam int LEN_W = 4;

    // saturation value of the digit count
    localparam logic [LEN_W-1:0] LEN_SAT =
        LEN_W'((NUMBER_DIGITS > 15) ? 15 : NUMBER_DIGITS);

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // result codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [DIG_W-1:0] bcd;
    } t_entry;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    scan;
        logic    shift;
        logic    wr_update;
        logic    wr_append;
        logic    cnt_dec;
        logic    res_load;
        logic    res_take;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic hit;
        logic pass_done;
        logic full;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/kvte_if.sv
// kvte_req_if / kvte_rsp_if: valid/ready channels of the key/value table engine
// standalone, no package dependency

// request channel
interface kvte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] lookup_key;
    logic [39:0] number_bcd;
    logic [3:0]  number_len;

    modport source (output valid, output req_type, output lookup_key,
                    output number_bcd, output number_len, input ready);
    modport sink   (input valid, input req_type, input lookup_key,
                    input number_bcd, input number_len, output ready);
endinterface

// response channel
interface kvte_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [39:0] found_bcd;
    logic [3:0]  found_len;

    modport source (output valid, output status, output found_bcd,
                    output found_len, input ready);
    modport sink   (input valid, input status, input found_bcd,
                    input found_len, output ready);
endinterface

// File: sv/kvte_ctrl.sv
// kvte_ctrl: request sequencer of the key/value table engine
// depends on kvte_pkg; drives the datapath through t_dp_cmd
module kvte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  kvte_pkg::t_dp_sts i_sts,
    output kvte_pkg::t_dp_cmd o_cmd
);
    import kvte_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.op == OP_NONE) begin
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    n_state = (i_sts.op == OP_DELETE) ? S_SHIFT : S_DONE;
                end else if (i_sts.pass_done) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_sts.pass_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_req_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no transaction is taken while reset is held
                o_req_ready    = i_rst_n;
                o_cmd.load_req = i_req_valid && i_rst_n;
            end
            S_SCAN: begin
                if (i_sts.op == OP_NONE) begin
                    o_cmd.res_load = 1'b1;
                end else if (i_sts.hit) begin
                    case (i_sts.op)
                        OP_ADD: begin
                            o_cmd.wr_update = 1'b1;
                            o_cmd.res_load  = 1'b1;
                        end
                        OP_SEARCH: begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_take = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (i_sts.pass_done) begin
                    o_cmd.res_load = 1'b1;
                    if (i_sts.op == OP_ADD) begin
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.wr_append = 1'b1;
                        end
                    end else begin
                        o_cmd.res_status = ST_MISSING;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.pass_done) begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.res_load = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: sv/kvte_dp.sv
// kvte_dp: table memory, scan pointer, compare and result registers
// depends on kvte_pkg; commanded by kvte_ctrl
module kvte_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvte_pkg::t_dp_cmd i_cmd,
    output kvte_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_req_type,
    input  logic [63:0]       i_lookup_key,
    input  logic [39:0]       i_number_bcd,
    input  logic [3:0]        i_number_len,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [39:0]       o_found_bcd,
    output logic [3:0]        o_found_len
);
    import kvte_pkg::*;

    // table memory
    t_entry mem [TABLE_DEPTH];

    // request registers
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [DIG_W-1:0] r_bcd;
    logic [LEN_W-1:0] r_len;

    // scan and fill state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    t_entry        r_rd_data;

    // result and output registers
    t_status          r_res_status;
    logic [DIG_W-1:0] r_res_bcd;
    logic [LEN_W-1:0] r_res_len;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [DIG_W-1:0] r_out_bcd;
    logic [LEN_W-1:0] r_out_len;

    logic          ptr_lt_cnt;
    logic          rd_en;
    logic          hit;
    logic          we;
    logic [AW-1:0] wa;
    t_entry        wd;
    logic [LEN_W-1:0] len_sat;

    assign ptr_lt_cnt = (r_ptr < r_count);
    assign rd_en      = (i_cmd.scan || i_cmd.shift) && ptr_lt_cnt;
    assign hit        = r_pend && (r_rd_data.key == r_key);

    // digit count saturation
    always_comb begin
        len_sat = i_number_len;
        if (32'(i_number_len) > NUMBER_DIGITS) begin
            len_sat = LEN_SAT;
        end
    end

    // write port select
    always_comb begin
        we = 1'b0;
        wa = r_pend_idx;
        wd = '{key: r_key, len: r_len, bcd: r_bcd};
        if (i_cmd.wr_update) begin
            we = 1'b1;
        end else if (i_cmd.wr_append) begin
            we = 1'b1;
            wa = r_count[AW-1:0];
        end else if (i_cmd.shift && r_pend) begin
            we = 1'b1;
            wa = r_pend_idx - AW'(1);
            wd = r_rd_data;
        end
    end

    // memory write
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_ptr[AW-1:0]];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= t_op'(i_req_type);
            r_key <= i_lookup_key[KEY_W-1:0];
            r_bcd <= i_number_bcd[DIG_W-1:0];
            r_len <= len_sat;
        end
    end

    // scan pointer and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_pend_idx <= '0;
        end else begin
            if (i_cmd.load_req) begin
                r_ptr  <= '0;
                r_pend <= 1'b0;
            end else begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_ptr      <= r_ptr + CW'(1);
                    r_pend_idx <= r_ptr[AW-1:0];
                end
            end
            if (i_cmd.wr_append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_bcd    <= i_cmd.res_take ? r_rd_data.bcd : '0;
            r_res_len    <= i_cmd.res_take ? r_rd_data.len : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_bcd    <= r_res_bcd;
            r_out_len    <= r_res_len;
        end
    end

    // status to controller
    assign o_sts.op        = r_op;
    assign o_sts.hit       = hit;
    assign o_sts.pass_done = !r_pend && !ptr_lt_cnt;
    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found_bcd = 40'(r_out_bcd);
    assign o_found_len = r_out_len;

endmodule

// File: sv/key_value_table_engine.sv
// key_value_table_engine: top level joining sequencer and datapath
// depends on kvte_pkg, kvte_if, kvte_ctrl and kvte_dp
//
// Keeps up to 64 key/number entries in insertion order in a single-port-read
// table memory and answers add, search and delete requests with one response
// each. A request walks the table one entry per cycle through the registered
// memory read port. A delete that finds its key moves the entries behind it
// down by one place. The response waits in an output register, and the next
// request is taken in the cycle after the result has moved there; while the
// previous response waits on the response ready, the result cannot move.
// The table is empty after reset and needs no clearing pass.
module key_value_table_engine (
    input logic         i_clk,
    input logic         i_rst_n,
    kvte_req_if.sink    i_req,
    kvte_rsp_if.source  o_rsp
);
    import kvte_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    req_ready;

    // sequencer
    kvte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    assign i_req.ready = req_ready;

    // table and result datapath
    kvte_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req.req_type),
        .i_lookup_key (i_req.lookup_key),
        .i_number_bcd (i_req.number_bcd),
        .i_number_len (i_req.number_len),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_found_bcd  (o_rsp.found_bcd),
        .o_found_len  (o_rsp.found_len)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench of the key/value table engine (phone book lookup)
// depends on kvte_pkg, the kvte_req_if / kvte_rsp_if interfaces and key_value_table_engine
module tb_top;
    import kvte_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int POOL_SIZE    = 96;

    // masks applied to request fields before they enter the mirror of the table
    localparam logic [63:0] KEY_MASK   = (KEY_W >= 64) ? '1 : 64'((64'd1 << KEY_W) - 1);
    localparam logic [39:0] DIGIT_MASK = (DIG_W >= 40) ? '1 : 40'((64'd1 << DIG_W) - 1);

    // directed keys
    localparam logic [63:0] KEY_ALICE = "ALICE";
    localparam logic [63:0] KEY_TOP   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_ONE   = 64'h0000_0000_0000_0001;

    // one answer of the engine
    typedef struct packed {
        t_status     status;
        logic [39:0] bcd;
        logic [3:0]  len;
    } t_phone_answer;

    logic i_clk;
    logic i_rst_n;

    kvte_req_if req ();
    kvte_rsp_if rsp ();

    key_value_table_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    // mirror of the phone book
    logic [63:0] book_keys [TABLE_DEPTH];
    logic [39:0] book_bcd  [TABLE_DEPTH];
    logic [3:0]  book_len  [TABLE_DEPTH];
    int          book_count;

    t_phone_answer answers_due [$];
    logic [63:0]   key_pool [POOL_SIZE];

    int  error_count;
    int  cycle_count;
    bit  idle_on;
    int  n_add, n_search, n_delete, n_none;
    int  n_full, n_missing, peak_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit hit with %0d answers outstanding",
                     $time, answers_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // response ready with random stalls while idle_on is set
    always @(negedge i_clk) begin
        rsp.ready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
    end

    // index of the first entry holding key, or book_count
    function automatic int find_entry(logic [63:0] key);
        for (int i = 0; i < book_count; i++) begin
            if (book_keys[i] == key) return i;
        end
        return book_count;
    endfunction

    // apply one request to the mirror and return the answer it earns
    function automatic t_phone_answer phonebook_apply(t_op op, logic [63:0] key_in,
                                                      logic [39:0] bcd_in,
                                                      logic [3:0] len_in);
        t_phone_answer ans;
        logic [63:0]   key;
        logic [39:0]   digits;
        logic [3:0]    len;
        int            pos;
        key    = key_in & KEY_MASK;
        digits = bcd_in & DIGIT_MASK;
        len    = (len_in > NUMBER_DIGITS) ? 4'(NUMBER_DIGITS) : len_in;
        ans    = '{status: ST_OK, bcd: '0, len: '0};
        pos    = find_entry(key);
        case (op)
            OP_ADD: begin
                n_add++;
                if (pos < book_count) begin
                    book_bcd[pos] = digits;
                    book_len[pos] = len;
                end else if (book_count >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    book_keys[book_count] = key;
                    book_bcd[book_count]  = digits;
                    book_len[book_count]  = len;
                    book_count++;
                end
            end
            OP_SEARCH: begin
                n_search++;
                if (pos < book_count) begin
                    ans.bcd = book_bcd[pos];
                    ans.len = book_len[pos];
                end else begin
                    ans.status = ST_MISSING;
                end
            end
            OP_DELETE: begin
                n_delete++;
                if (pos < book_count) begin
                    for (int i = pos; i + 1 < book_count; i++) begin
                        book_keys[i] = book_keys[i + 1];
                        book_bcd[i]  = book_bcd[i + 1];
                        book_len[i]  = book_len[i + 1];
                    end
                    book_count--;
                end else begin
                    ans.status = ST_MISSING;
                end
            end
            default: n_none++;
        endcase
        if (ans.status == ST_FULL) n_full++;
        if (ans.status == ST_MISSING) n_missing++;
        if (book_count > peak_count) peak_count = book_count;
        return ans;
    endfunction

    // random key of one to eight bytes, with the all-zero and all-one keys now and then
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int          nbytes;
        k      = {$urandom(), $urandom()};
        nbytes = $urandom_range(1, 8);
        if (nbytes < 8) k &= (64'd1 << (8 * nbytes)) - 1;
        case ($urandom_range(39))
            0: k = '0;
            1: k = '1;
            default: ;
        endcase
        return k;
    endfunction

    // key from the table, from the shared pool or brand new
    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && book_count > 0) return book_keys[$urandom_range(book_count - 1)];
        if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return fresh_key();
    endfunction

    function automatic logic [39:0] random_bcd();
        return 40'({$urandom(), $urandom()});
    endfunction

    // digit count, mostly legal, sometimes above the saturation point
    function automatic logic [3:0] random_len();
        return ($urandom_range(9) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(NUMBER_DIGITS));
    endfunction

    // drive one request transaction and record its answer once accepted
    task automatic send_request(t_op op, logic [63:0] key, logic [39:0] bcd,
                                logic [3:0] len);
        if (idle_on && $urandom_range(99) < 7) begin
            @(negedge i_clk);
            req.valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        req.valid      <= 1'b1;
        req.req_type   <= op;
        req.lookup_key <= key;
        req.number_bcd <= bcd;
        req.number_len <= len;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        answers_due.push_back(phonebook_apply(op, key, bcd, len));
    endtask

    // mismatch report
    task automatic report_mismatch(string field, logic [39:0] want, logic [39:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    // check each response transaction against the oldest answer due
    always @(posedge i_clk) begin : check_answers
        t_phone_answer due;
        if (i_rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
                error_count++;
                $display("%0t: response with no request pending, actual %h %h %h",
                         $time, rsp.status, rsp.found_bcd, rsp.found_len);
            end else begin
                due = answers_due.pop_front();
                if (rsp.status !== due.status)
                    report_mismatch("status", 40'(due.status), 40'(rsp.status));
                if (rsp.found_bcd !== due.bcd)
                    report_mismatch("found_bcd", due.bcd, rsp.found_bcd);
                if (rsp.found_len !== due.len)
                    report_mismatch("found_len", 40'(due.len), 40'(rsp.found_len));
            end
        end
    end

    // extremes of the fields, every operation, update, saturation, shifting delete
    task automatic test_directed_ops();
        send_request(OP_SEARCH, '0, '0, '0);
        send_request(OP_DELETE, '0, '0, '0);
        send_request(OP_NONE, '0, '0, '0);
        send_request(OP_ADD, '0, '0, '0);
        send_request(OP_ADD, '1, '1, 4'd15);
        send_request(OP_ADD, KEY_ALICE, 40'h55_5123_4567, 4'd10);
        send_request(OP_SEARCH, '0, '1, 4'd15);
        send_request(OP_SEARCH, '1, '0, '0);
        send_request(OP_ADD, KEY_ALICE, 40'h00_0765_4321, 4'd7);
        send_request(OP_SEARCH, KEY_ALICE, '0, '0);
        send_request(OP_ADD, KEY_TOP, 40'h98_7654_3210, 4'd11);
        send_request(OP_DELETE, '0, '1, 4'd15);
        send_request(OP_SEARCH, '1, '0, '0);
        send_request(OP_SEARCH, '0, '0, '0);
        send_request(OP_DELETE, '1, '0, '0);
        send_request(OP_SEARCH, KEY_ALICE, '1, 4'd15);
        send_request(OP_NONE, '1, '1, 4'd15);
        send_request(OP_SEARCH, KEY_TOP, '0, '0);
        send_request(OP_DELETE, KEY_ALICE, '1, 4'd15);
        send_request(OP_DELETE, KEY_TOP, '0, '0);
        send_request(OP_SEARCH, KEY_TOP, '0, '0);
        send_request(OP_ADD, KEY_ONE, 40'h00_0000_0009, 4'd1);
        send_request(OP_SEARCH, KEY_ONE, '0, '0);
        send_request(OP_DELETE, KEY_ONE, '0, '0);
    endtask

    // fill the table, overflow it, work on it while full, then empty it
    task automatic test_table_full();
        logic [63:0] k;
        while (book_count < TABLE_DEPTH) begin
            do k = fresh_key(); while (find_entry(k) < book_count);
            send_request(OP_ADD, k, random_bcd(), random_len());
        end
        repeat (4) begin
            do k = fresh_key(); while (find_entry(k) < book_count);
            send_request(OP_ADD, k, random_bcd(), random_len());
        end
        send_request(OP_ADD, book_keys[$urandom_range(TABLE_DEPTH - 1)], random_bcd(),
                     random_len());
        send_request(OP_SEARCH, book_keys[TABLE_DEPTH - 1], random_bcd(), random_len());
        send_request(OP_SEARCH, book_keys[0], random_bcd(), random_len());
        send_request(OP_NONE, fresh_key(), random_bcd(), random_len());
        send_request(OP_DELETE, book_keys[TABLE_DEPTH / 2], random_bcd(), random_len());
        repeat (2) begin
            do k = fresh_key(); while (find_entry(k) < book_count);
            send_request(OP_ADD, k, random_bcd(), random_len());
        end
        // empty it in random order, looking entries up on the way
        while (book_count > 0) begin
            if ($urandom_range(2) == 0)
                send_request(OP_SEARCH, book_keys[$urandom_range(book_count - 1)],
                             random_bcd(), random_len());
            send_request(OP_DELETE, book_keys[$urandom_range(book_count - 1)],
                         random_bcd(), random_len());
        end
    endtask

    // mixed traffic that grows the table toward full and shrinks it back toward empty
    task automatic test_random_traffic(int count, bit idling);
        bit  growing;
        int  r;
        t_op op;
        idle_on = idling;
        growing = 1'b1;
        repeat (count) begin
            if (book_count >= TABLE_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
            if (book_count == 0) growing = 1'b1;
            r = $urandom_range(99);
            if (r < 5)
                op = OP_NONE;
            else if (r < (growing ? 70 : 20))
                op = OP_ADD;
            else if (r < (growing ? 90 : 45))
                op = OP_SEARCH;
            else
                op = OP_DELETE;
            send_request(op, pick_key(), random_bcd(), random_len());
        end
        idle_on = 1'b1;
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.req_type   = OP_NONE;
        req.lookup_key = '0;
        req.number_bcd = '0;
        req.number_len = '0;
        idle_on        = 1'b1;
        book_count     = 0;
        foreach (key_pool[i]) key_pool[i] = fresh_key();
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_table_full();
        test_random_traffic(700, 1'b1);
        test_random_traffic(400, 1'b0);
        test_random_traffic(650, 1'b1);

        @(negedge i_clk);
        req.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d add, %0d search, %0d delete, %0d unused code",
                 n_add, n_search, n_delete, n_none);
        $display("answers: %0d table full, %0d key missing; peak occupancy %0d of %0d",
                 n_full, n_missing, peak_count, TABLE_DEPTH);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
